>>> hdl/grid_ray_cell_walker_macros.svh
// Assertion macros shared by the grid ray cell walker RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef GRID_RAY_CELL_WALKER_MACROS_SVH
`define GRID_RAY_CELL_WALKER_MACROS_SVH
`ifndef SYNTHESIS
`define GRCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("grcw assertion failed");
`define GRCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("grcw assertion failed");
`else
`define GRCW_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define GRCW_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/grcw_pkg.sv
// Shared types and constants of the grid ray cell walker.
// Used by the controller, the datapath, the arithmetic units and the top level.
package grcw_pkg;

	localparam int COORD_W = 24;
	localparam int CELL_W  = 26;
	localparam int CNT_W   = 7;
	localparam logic [CNT_W-1:0] MAX_CELLS = 7'd64;
	localparam logic [CNT_W-1:0] LIMIT_SAT = 7'd127;

	// Divider sizing: long divisions take a 49-bit dividend, short ones 26 bits.
	localparam int DIV_W           = 49;
	localparam int DIV_D_W         = 25;
	localparam int DIV_STEP_W      = 6;
	localparam int DIV_LONG_STEPS  = 49;
	localparam int DIV_SHORT_STEPS = 26;

	localparam int SQ_W    = 50;
	localparam int ROOT_W  = 25;
	localparam int MUL_W   = 26;
	localparam int PROD_W  = 52;

	typedef enum logic [4:0] {
		OP_NONE      = 5'd0,
		OP_LOAD      = 5'd1,
		OP_MUL_AA    = 5'd2,
		OP_MUL_BB    = 5'd3,
		OP_MUL_MM    = 5'd4,
		OP_SQRT_GO   = 5'd5,
		OP_USABLE    = 5'd6,
		OP_MUL_PB    = 5'd7,
		OP_DIV_PB    = 5'd8,
		OP_PB_CAP    = 5'd9,
		OP_DIV_CELL  = 5'd10,
		OP_CELL_CAP  = 5'd11,
		OP_WALK_INIT = 5'd12,
		OP_ITER      = 5'd13,
		OP_EMIT      = 5'd14,
		OP_MUL_T1    = 5'd15,
		OP_MUL_T2    = 5'd16,
		OP_STEP      = 5'd17
	} dp_op_t;

	typedef enum logic [2:0] {
		DSEL_OX   = 3'd0,
		DSEL_OY   = 3'd1,
		DSEL_TX   = 3'd2,
		DSEL_TY   = 3'd3,
		DSEL_SPAN = 3'd4
	} div_sel_t;

	typedef struct packed {
		dp_op_t   op;
		div_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		logic short_ray;
		logic sqrt_busy;
		logic div_busy;
		logic origin_cell;
		logic at_end;
		logic last;
	} dp_status_t;

endpackage

>>> hdl/grcw_div.sv
// Restoring divider, one quotient bit per cycle, long or short dividend.
// Depends on grcw_pkg for its widths.
module grcw_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          short_mode,
	input  logic [grcw_pkg::DIV_W-1:0]    dividend,
	input  logic [grcw_pkg::DIV_D_W-1:0]  divisor,
	output logic                          busy,
	output logic [grcw_pkg::DIV_W-1:0]    quo,
	output logic [grcw_pkg::DIV_D_W-1:0]  rem
);

	logic [grcw_pkg::DIV_W-1:0]      q_q;
	logic [grcw_pkg::DIV_D_W-1:0]    r_q;
	logic [grcw_pkg::DIV_D_W-1:0]    d_q;
	logic [grcw_pkg::DIV_STEP_W-1:0] cnt_q;
	logic                            busy_q;
	logic [grcw_pkg::DIV_D_W:0]      r_shift;
	logic [grcw_pkg::DIV_D_W:0]      r_diff;
	logic                            ge;

	assign r_shift = {r_q, q_q[grcw_pkg::DIV_W-1]};
	assign r_diff  = r_shift - {1'b0, d_q};
	assign ge      = r_shift >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= short_mode ? grcw_pkg::DIV_STEP_W'(grcw_pkg::DIV_SHORT_STEPS)
			                     : grcw_pkg::DIV_STEP_W'(grcw_pkg::DIV_LONG_STEPS);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= cnt_q != grcw_pkg::DIV_STEP_W'(1);
		end
	end

	// A short dividend is left-aligned so the quotient lands in the low bits.
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= short_mode ? {dividend[grcw_pkg::DIV_SHORT_STEPS-1:0],
			                     (grcw_pkg::DIV_W - grcw_pkg::DIV_SHORT_STEPS)'(0)}
			                  : dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (busy_q) begin
			q_q <= {q_q[grcw_pkg::DIV_W-2:0], ge};
			r_q <= ge ? r_diff[grcw_pkg::DIV_D_W-1:0] : r_shift[grcw_pkg::DIV_D_W-1:0];
		end
	end

	assign busy = busy_q;
	assign quo  = q_q;
	assign rem  = r_q;

endmodule

>>> hdl/grcw_sqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Depends on grcw_pkg for its widths.
module grcw_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [grcw_pkg::SQ_W-1:0]    radicand,
	output logic                         busy,
	output logic [grcw_pkg::ROOT_W-1:0]  root
);

	logic [grcw_pkg::SQ_W-1:0]   x_q;
	logic [grcw_pkg::ROOT_W+1:0] rem_q;
	logic [grcw_pkg::ROOT_W-1:0] root_q;
	logic [4:0]                  cnt_q;
	logic                        busy_q;
	logic [grcw_pkg::ROOT_W+3:0] r2;
	logic [grcw_pkg::ROOT_W+3:0] trial;
	logic [grcw_pkg::ROOT_W+3:0] r_diff;
	logic                        ge;

	assign r2     = {rem_q, x_q[grcw_pkg::SQ_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign r_diff = r2 - trial;
	assign ge     = r2 >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(grcw_pkg::ROOT_W);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= cnt_q != 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[grcw_pkg::SQ_W-3:0], 2'b00};
			rem_q  <= ge ? r_diff[grcw_pkg::ROOT_W+1:0] : r2[grcw_pkg::ROOT_W+1:0];
			root_q <= {root_q[grcw_pkg::ROOT_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

>>> hdl/grcw_dp.sv
// Datapath of the grid ray cell walker: ray setup registers, shared multiplier,
// square root and divider units, walk state and the result register.
// Depends on grcw_pkg, grcw_div, grcw_sqrt and the assertion macro header.
`include "grid_ray_cell_walker_macros.svh"
module grcw_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  grcw_pkg::dp_cmd_t                   cmd,
	output grcw_pkg::dp_status_t                status,
	input  logic signed [grcw_pkg::COORD_W-1:0] origin_x,
	input  logic signed [grcw_pkg::COORD_W-1:0] origin_y,
	input  logic signed [grcw_pkg::COORD_W-1:0] target_x,
	input  logic signed [grcw_pkg::COORD_W-1:0] target_y,
	input  logic [15:0]                         grid_size,
	input  logic [15:0]                         trim_dist,
	output logic signed [grcw_pkg::COORD_W-1:0] cell_x,
	output logic signed [grcw_pkg::COORD_W-1:0] cell_y,
	output logic                                last_cell,
	output logic                                truncated
);

	localparam int CW = grcw_pkg::COORD_W;
	localparam int LW = grcw_pkg::CELL_W;

	logic signed [CW-1:0]  ox_q, oy_q, tx_q, ty_q;
	logic signed [CW-1:0]  ocx_q, ocy_q, ex_q, ey_q;
	logic [CW-1:0]         adx_q, ady_q;
	logic                  xneg_q, xpos_q, yneg_q, ypos_q;
	logic [15:0]           vs_q, m_q, remx_q, remy_q;
	logic [grcw_pkg::PROD_W-1:0]  prod_q, p1_q;
	logic [grcw_pkg::SQ_W-1:0]    sq_q;
	logic [grcw_pkg::ROOT_W-1:0]  len_q, usable_q;
	logic [grcw_pkg::CNT_W-1:0]   limit_q, iter_q, count_q;
	logic signed [LW-1:0]  cx_q, cy_q;
	logic [CW-1:0]         ax_q, ay_q;

	logic signed [CW:0]    dx_w, dy_w;
	logic [CW:0]           adx_w, ady_w;
	logic [grcw_pkg::MUL_W-1:0]  mul_a, mul_b;
	logic                  mul_en;

	logic                  sqrt_busy;
	logic [grcw_pkg::ROOT_W-1:0] sqrt_root;
	logic                  div_start, div_short, div_busy;
	logic [grcw_pkg::DIV_W-1:0]   div_dividend, div_quo;
	logic [grcw_pkg::DIV_D_W-1:0] div_divisor, div_rem;

	logic signed [CW-1:0]  cell_src;
	logic [CW-1:0]         cell_abs;
	logic                  cell_neg;
	logic [LW-1:0]         span_w;
	logic                  rem_nz;
	logic [CW-1:0]         qmag;
	logic signed [CW-1:0]  floor_q;
	logic [15:0]           floor_rem;
	logic [CW-1:0]         pb_off;
	logic signed [CW:0]    pb_x, pb_y;
	logic [5:0]            span_q6;

	logic                  at_end, origin_cell, last_w, lt_x, lt_y;
	logic [grcw_pkg::CNT_W-1:0] iter_nx, count_nx;

	assign dx_w  = {target_x[CW-1], target_x} - {origin_x[CW-1], origin_x};
	assign dy_w  = {target_y[CW-1], target_y} - {origin_y[CW-1], origin_y};
	assign adx_w = dx_w[CW] ? (CW+1)'(-dx_w) : (CW+1)'(dx_w);
	assign ady_w = dy_w[CW] ? (CW+1)'(-dy_w) : (CW+1)'(dy_w);

	// Shared multiplier; its product is always registered before use.
	always_comb begin
		mul_a  = '0;
		mul_b  = '0;
		mul_en = 1'b1;
		case (cmd.op)
			grcw_pkg::OP_MUL_AA: begin
				mul_a = 26'(adx_q);
				mul_b = 26'(adx_q);
			end
			grcw_pkg::OP_MUL_BB: begin
				mul_a = 26'(ady_q);
				mul_b = 26'(ady_q);
			end
			grcw_pkg::OP_MUL_MM: begin
				mul_a = 26'(m_q);
				mul_b = 26'(m_q);
			end
			grcw_pkg::OP_MUL_PB: begin
				mul_a = (cmd.sel == grcw_pkg::DSEL_OY) ? 26'(ady_q) : 26'(adx_q);
				mul_b = 26'(usable_q);
			end
			grcw_pkg::OP_MUL_T1: begin
				mul_a = 26'(ax_q);
				mul_b = 26'(ady_q);
			end
			grcw_pkg::OP_MUL_T2: begin
				mul_a = 26'(ay_q);
				mul_b = 26'(adx_q);
			end
			default: mul_en = 1'b0;
		endcase
	end

	// Source of a division by the cell size, and the floor correction of its result.
	always_comb begin
		case (cmd.sel)
			grcw_pkg::DSEL_OX: cell_src = ox_q;
			grcw_pkg::DSEL_OY: cell_src = oy_q;
			grcw_pkg::DSEL_TX: cell_src = tx_q;
			grcw_pkg::DSEL_TY: cell_src = ty_q;
			default:           cell_src = '0;
		endcase
	end
	assign cell_neg  = cell_src[CW-1];
	assign cell_abs  = cell_neg ? CW'(-cell_src) : CW'(cell_src);
	assign span_w    = LW'(usable_q) + LW'(vs_q) - LW'(1);
	assign rem_nz    = div_rem != '0;
	assign qmag      = div_quo[CW-1:0];
	assign floor_q   = cell_neg ? CW'(-(qmag + CW'(rem_nz))) : qmag;
	assign floor_rem = (cell_neg && rem_nz) ? vs_q - div_rem[15:0] : div_rem[15:0];
	assign span_q6   = div_quo[5:0];

	assign pb_off = div_quo[CW-1:0];
	assign pb_x   = xneg_q ? {ox_q[CW-1], ox_q} - {1'b0, pb_off}
	                       : {ox_q[CW-1], ox_q} + {1'b0, pb_off};
	assign pb_y   = yneg_q ? {oy_q[CW-1], oy_q} - {1'b0, pb_off}
	                       : {oy_q[CW-1], oy_q} + {1'b0, pb_off};

	always_comb begin
		div_start    = 1'b0;
		div_short    = 1'b0;
		div_dividend = prod_q[grcw_pkg::DIV_W-1:0];
		div_divisor  = len_q;
		case (cmd.op)
			grcw_pkg::OP_DIV_PB: div_start = 1'b1;
			grcw_pkg::OP_DIV_CELL: begin
				div_start    = 1'b1;
				div_short    = 1'b1;
				div_divisor  = grcw_pkg::DIV_D_W'(vs_q);
				div_dividend = (cmd.sel == grcw_pkg::DSEL_SPAN) ?
				               grcw_pkg::DIV_W'(span_w) : grcw_pkg::DIV_W'(cell_abs);
			end
			default: ;
		endcase
	end

	grcw_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == grcw_pkg::OP_SQRT_GO),
		.radicand (sq_q),
		.busy     (sqrt_busy),
		.root     (sqrt_root)
	);

	grcw_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (div_start),
		.short_mode (div_short),
		.dividend   (div_dividend),
		.divisor    (div_divisor),
		.busy       (div_busy),
		.quo        (div_quo),
		.rem        (div_rem)
	);

	// Walk decisions.
	assign origin_cell = (cx_q == LW'(ocx_q)) && (cy_q == LW'(ocy_q));
	assign at_end      = (cx_q == LW'(ex_q)) && (cy_q == LW'(ey_q));
	assign iter_nx     = iter_q + 1'b1;
	assign count_nx    = count_q + 1'b1;
	// A cell is the last one when the walk ends here or the next visit would hit a limit.
	assign last_w      = at_end || (iter_nx >= limit_q) || (count_nx >= grcw_pkg::MAX_CELLS);
	assign lt_x = (xneg_q || xpos_q) && (!(yneg_q || ypos_q) || (p1_q < prod_q));
	assign lt_y = (yneg_q || ypos_q) && (!(xneg_q || xpos_q) || (prod_q < p1_q));

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		case (cmd.op)
			grcw_pkg::OP_LOAD: begin
				ox_q   <= origin_x;
				oy_q   <= origin_y;
				xneg_q <= dx_w[CW];
				xpos_q <= !dx_w[CW] && (dx_w != '0);
				yneg_q <= dy_w[CW];
				ypos_q <= !dy_w[CW] && (dy_w != '0);
				adx_q  <= adx_w[CW-1:0];
				ady_q  <= ady_w[CW-1:0];
				vs_q   <= (grid_size == 16'd0) ? 16'd1 : grid_size;
				m_q    <= trim_dist;
			end
			grcw_pkg::OP_MUL_BB: sq_q <= prod_q[grcw_pkg::SQ_W-1:0];
			grcw_pkg::OP_MUL_MM: sq_q <= sq_q + prod_q[grcw_pkg::SQ_W-1:0];
			grcw_pkg::OP_USABLE: begin
				len_q    <= sqrt_root;
				usable_q <= sqrt_root - grcw_pkg::ROOT_W'(m_q);
			end
			grcw_pkg::OP_PB_CAP: begin
				if (cmd.sel == grcw_pkg::DSEL_OY) begin
					ty_q <= pb_y[CW-1:0];
				end else begin
					tx_q <= pb_x[CW-1:0];
				end
			end
			grcw_pkg::OP_CELL_CAP: begin
				case (cmd.sel)
					grcw_pkg::DSEL_OX: begin
						ocx_q  <= floor_q;
						remx_q <= floor_rem;
					end
					grcw_pkg::DSEL_OY: begin
						ocy_q  <= floor_q;
						remy_q <= floor_rem;
					end
					grcw_pkg::DSEL_TX: ex_q <= floor_q;
					grcw_pkg::DSEL_TY: ey_q <= floor_q;
					default: begin
						// Visit limit is ceil(usable / size) * 3 + 8, saturated.
						limit_q <= (div_quo >= grcw_pkg::DIV_W'(40)) ? grcw_pkg::LIMIT_SAT
						         : grcw_pkg::CNT_W'({span_q6, 1'b0}) + grcw_pkg::CNT_W'(span_q6)
						           + grcw_pkg::CNT_W'(8);
					end
				endcase
			end
			grcw_pkg::OP_WALK_INIT: begin
				cx_q <= LW'(ocx_q);
				cy_q <= LW'(ocy_q);
				ax_q <= xpos_q ? CW'(vs_q - remx_q) : (xneg_q ? CW'(remx_q) : '0);
				ay_q <= ypos_q ? CW'(vs_q - remy_q) : (yneg_q ? CW'(remy_q) : '0);
			end
			grcw_pkg::OP_EMIT: begin
				cell_x    <= cx_q[CW-1:0];
				cell_y    <= cy_q[CW-1:0];
				last_cell <= last_w;
				truncated <= last_w && !at_end;
			end
			grcw_pkg::OP_MUL_T2: p1_q <= prod_q;
			grcw_pkg::OP_STEP: begin
				if (lt_x || !lt_y) begin
					cx_q <= xneg_q ? cx_q - LW'(1) : cx_q + LW'(1);
					ax_q <= ax_q + CW'(vs_q);
				end
				if (lt_y || !lt_x) begin
					cy_q <= yneg_q ? cy_q - LW'(1) : cy_q + LW'(1);
					ay_q <= ay_q + CW'(vs_q);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q  <= '0;
			count_q <= '0;
		end else begin
			case (cmd.op)
				grcw_pkg::OP_WALK_INIT: begin
					iter_q  <= '0;
					count_q <= '0;
				end
				grcw_pkg::OP_ITER: iter_q <= iter_nx;
				grcw_pkg::OP_EMIT: begin
					iter_q  <= iter_nx;
					count_q <= count_nx;
				end
				default: ;
			endcase
		end
	end

	assign status.short_ray   = {2'b00, sq_q} <= prod_q;
	assign status.sqrt_busy   = sqrt_busy;
	assign status.div_busy    = div_busy;
	assign status.origin_cell = origin_cell;
	assign status.at_end      = at_end;
	assign status.last        = last_w;

	`GRCW_ASSERT_IMP(a_emit_in_bounds, clk, arst_n, cmd.op == grcw_pkg::OP_EMIT, (count_q < grcw_pkg::MAX_CELLS) && (iter_q < limit_q))
	`GRCW_ASSERT_NXT(a_step_moves, clk, arst_n, cmd.op == grcw_pkg::OP_STEP, (cx_q != $past(cx_q)) || (cy_q != $past(cy_q)))
	`GRCW_ASSERT_IMP(a_div_free, clk, arst_n, div_start, !div_busy)

endmodule

>>> hdl/grcw_ctrl.sv
// Controller of the grid ray cell walker: sequences the ray setup and the cell walk,
// and owns both stream handshakes. Depends on grcw_pkg and the assertion macro header.
`include "grid_ray_cell_walker_macros.svh"
module grcw_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output grcw_pkg::dp_cmd_t    cmd,
	input  grcw_pkg::dp_status_t status
);

	typedef enum logic [19:0] {
		ST_IDLE   = 20'h00001,
		ST_SQX    = 20'h00002,
		ST_SQY    = 20'h00004,
		ST_SQM    = 20'h00008,
		ST_TEST   = 20'h00010,
		ST_SQRT   = 20'h00020,
		ST_SQRT_W = 20'h00040,
		ST_USE    = 20'h00080,
		ST_PBM    = 20'h00100,
		ST_PBD    = 20'h00200,
		ST_PBW    = 20'h00400,
		ST_PBE    = 20'h00800,
		ST_CD     = 20'h01000,
		ST_CW     = 20'h02000,
		ST_CE     = 20'h04000,
		ST_INIT   = 20'h08000,
		ST_CHK    = 20'h10000,
		ST_M1     = 20'h20000,
		ST_M2     = 20'h40000,
		ST_STEP   = 20'h80000
	} state_t;

	state_t              state_q, state_nx;
	grcw_pkg::div_sel_t  sel_q, sel_nx;
	logic                out_valid_q;
	logic                emit;

	always_comb begin
		state_nx = state_q;
		sel_nx   = sel_q;
		cmd.op   = grcw_pkg::OP_NONE;
		cmd.sel  = sel_q;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op   = grcw_pkg::OP_LOAD;
					state_nx = ST_SQX;
				end
			end
			ST_SQX: begin
				cmd.op   = grcw_pkg::OP_MUL_AA;
				state_nx = ST_SQY;
			end
			ST_SQY: begin
				cmd.op   = grcw_pkg::OP_MUL_BB;
				state_nx = ST_SQM;
			end
			ST_SQM: begin
				cmd.op   = grcw_pkg::OP_MUL_MM;
				state_nx = ST_TEST;
			end
			ST_TEST: state_nx = status.short_ray ? ST_IDLE : ST_SQRT;
			ST_SQRT: begin
				cmd.op   = grcw_pkg::OP_SQRT_GO;
				state_nx = ST_SQRT_W;
			end
			ST_SQRT_W: begin
				if (!status.sqrt_busy) begin
					state_nx = ST_USE;
				end
			end
			ST_USE: begin
				cmd.op   = grcw_pkg::OP_USABLE;
				sel_nx   = grcw_pkg::DSEL_OX;
				state_nx = ST_PBM;
			end
			ST_PBM: begin
				cmd.op   = grcw_pkg::OP_MUL_PB;
				state_nx = ST_PBD;
			end
			ST_PBD: begin
				cmd.op   = grcw_pkg::OP_DIV_PB;
				state_nx = ST_PBW;
			end
			ST_PBW: begin
				if (!status.div_busy) begin
					state_nx = ST_PBE;
				end
			end
			ST_PBE: begin
				cmd.op = grcw_pkg::OP_PB_CAP;
				if (sel_q == grcw_pkg::DSEL_OY) begin
					sel_nx   = grcw_pkg::DSEL_OX;
					state_nx = ST_CD;
				end else begin
					sel_nx   = grcw_pkg::DSEL_OY;
					state_nx = ST_PBM;
				end
			end
			ST_CD: begin
				cmd.op   = grcw_pkg::OP_DIV_CELL;
				state_nx = ST_CW;
			end
			ST_CW: begin
				if (!status.div_busy) begin
					state_nx = ST_CE;
				end
			end
			ST_CE: begin
				cmd.op = grcw_pkg::OP_CELL_CAP;
				if (sel_q == grcw_pkg::DSEL_SPAN) begin
					state_nx = ST_INIT;
				end else begin
					sel_nx   = grcw_pkg::div_sel_t'(sel_q + 3'd1);
					state_nx = ST_CD;
				end
			end
			ST_INIT: begin
				cmd.op   = grcw_pkg::OP_WALK_INIT;
				state_nx = ST_CHK;
			end
			ST_CHK: begin
				if (status.origin_cell) begin
					cmd.op   = grcw_pkg::OP_ITER;
					state_nx = status.at_end ? ST_IDLE : ST_M1;
				end else if (!out_valid_q || m_tready) begin
					cmd.op   = grcw_pkg::OP_EMIT;
					state_nx = status.last ? ST_IDLE : ST_M1;
				end
			end
			ST_M1: begin
				cmd.op   = grcw_pkg::OP_MUL_T1;
				state_nx = ST_M2;
			end
			ST_M2: begin
				cmd.op   = grcw_pkg::OP_MUL_T2;
				state_nx = ST_STEP;
			end
			ST_STEP: begin
				cmd.op   = grcw_pkg::OP_STEP;
				state_nx = ST_CHK;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	assign emit = cmd.op == grcw_pkg::OP_EMIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			sel_q       <= grcw_pkg::DSEL_OX;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nx;
			sel_q       <= sel_nx;
			out_valid_q <= emit || (out_valid_q && !m_tready);
		end
	end

	assign m_tvalid = out_valid_q;

	`GRCW_ASSERT_IMP(a_emit_no_overwrite, clk, arst_n, emit, !out_valid_q || m_tready)
	`GRCW_ASSERT_NXT(a_emit_shows, clk, arst_n, emit, out_valid_q)
	`GRCW_ASSERT_IMP(a_idle_to_load, clk, arst_n, s_tvalid && s_tready, cmd.op == grcw_pkg::OP_LOAD)

endmodule

>>> hdl/grid_ray_cell_walker.sv
// Top level of the grid ray cell walker: APB register file, controller and datapath.
// Depends on grcw_pkg, grcw_ctrl and grcw_dp.

// One ray is taken at a time. A ray whose length does not exceed the margin is
// dropped once its squared length has been tested. Any other ray goes through
// setup: a square root, then two pull-back divisions and five divisions by the
// cell size, the divisions all on one shared serial divider, plus multiplier
// work. The walk then passes the origin cell and, for each emitted cell, checks
// and emits it, forms both crossing-time products in turn on the shared
// multiplier and steps. The next ray is accepted only after the walk ends, any
// output stalls included. The last result waits in an output register without
// blocking the next ray.
module grid_ray_cell_walker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // origin_x, origin_y, target_x, target_y
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // cell_x, cell_y
	output logic        m_tlast,   // last_cell
	output logic        m_tuser,   // truncated
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam logic REG_GRID_SIZE = 1'b0;

	logic [15:0]          grid_size_q;
	logic [15:0]          trim_dist_q;
	grcw_pkg::dp_cmd_t    cmd;
	grcw_pkg::dp_status_t status;
	logic signed [23:0]   cell_x, cell_y;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_size_q <= 16'd256;
			trim_dist_q <= 16'd0;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_GRID_SIZE) begin
				grid_size_q <= pwdata[15:0];
			end else begin
				trim_dist_q <= pwdata[15:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_GRID_SIZE) ? {16'd0, grid_size_q}
	                                            : {16'd0, trim_dist_q};

	grcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.status   (status)
	);

	grcw_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.origin_x  (s_tdata[23:0]),
		.origin_y  (s_tdata[47:24]),
		.target_x  (s_tdata[71:48]),
		.target_y  (s_tdata[95:72]),
		.grid_size (grid_size_q),
		.trim_dist (trim_dist_q),
		.cell_x    (cell_x),
		.cell_y    (cell_y),
		.last_cell (m_tlast),
		.truncated (m_tuser)
	);

	assign m_tdata = {cell_y, cell_x};

endmodule

>>> dv/tb_grid_ray_cell_walker.sv
// Self-checking testbench of grid_ray_cell_walker: a 2D grid cell walk checked against
// a predictor. Depends on the RTL top level grid_ray_cell_walker and nothing else.
`default_nettype none

class cell_walk_scoreboard;
	typedef struct {
		logic [23:0] cx;
		logic [23:0] cy;
		logic        last;
		logic        trunc;
	} cell_t;

	cell_t       pending_cells[$];
	longint      cell_edge;
	longint      margin;
	int          mismatches;

	function new();
		cell_edge  = 256;
		margin     = 0;
		mismatches = 0;
	endfunction

	static function longint root_floor(longint v);
		longint res;
		longint b;
		res = 0;
		b = longint'(1) << 62;
		while (b > v)
			b = b >>> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >>> 1) + b;
			end else begin
				res = res >>> 1;
			end
			b = b >>> 2;
		end
		return res;
	endfunction

	static function longint div_down(longint a, longint b);
		longint q;
		q = a / b;
		if ((a % b) != 0 && a < 0)
			q = q - 1;
		return q;
	endfunction

	// Queues the cells the ray visits, the origin cell apart, as expected transfers.
	function void note_ray(logic [23:0] oxr, logic [23:0] oyr, logic [23:0] txr,
		logic [23:0] tyr);
		longint ox, oy, dx, dy, vs, adx, ady, sq, len, usable, lim, iter;
		longint ex, ey, cx, cy, ocx, ocy, sx, sy, ax, ay, off;
		int     n;
		bit     trunc, lt_x, lt_y;
		cell_t  c;
		ox = longint'($signed(oxr));
		oy = longint'($signed(oyr));
		dx = longint'($signed(txr)) - ox;
		dy = longint'($signed(tyr)) - oy;
		vs = (cell_edge == 0) ? 1 : cell_edge;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		sq = adx * adx + ady * ady;
		if (sq <= margin * margin)
			return;
		len = root_floor(sq);
		usable = len - margin;
		off = (adx * usable) / len;
		ex = div_down(dx < 0 ? ox - off : ox + off, vs);
		off = (ady * usable) / len;
		ey = div_down(dy < 0 ? oy - off : oy + off, vs);
		cx = div_down(ox, vs);
		cy = div_down(oy, vs);
		ocx = cx;
		ocy = cy;
		sx = dx > 0 ? 1 : (dx < 0 ? -1 : 0);
		sy = dy > 0 ? 1 : (dy < 0 ? -1 : 0);
		ax = 0;
		ay = 0;
		if (sx > 0) ax = (cx + 1) * vs - ox;
		else if (sx < 0) ax = ox - cx * vs;
		if (sy > 0) ay = (cy + 1) * vs - oy;
		else if (sy < 0) ay = oy - cy * vs;
		lim = ((usable + vs - 1) / vs) * 3 + 8;
		iter = 0;
		n = 0;
		trunc = 0;
		forever begin
			if (iter >= lim) begin
				trunc = 1;
				break;
			end
			iter++;
			if (cx != ocx || cy != ocy) begin
				if (n >= 64) begin
					trunc = 1;
					break;
				end
				c.cx = cx[23:0];
				c.cy = cy[23:0];
				c.last = 0;
				c.trunc = 0;
				pending_cells = {pending_cells, c};
				n++;
			end
			if (cx == ex && cy == ey)
				break;
			lt_x = sx != 0 && (sy == 0 || ax * ady < ay * adx);
			lt_y = sy != 0 && (sx == 0 || ay * adx < ax * ady);
			if (lt_x) begin
				cx += sx;
				ax += vs;
			end else if (lt_y) begin
				cy += sy;
				ay += vs;
			end else begin
				cx += sx;
				cy += sy;
				ax += vs;
				ay += vs;
			end
		end
		if (n > 0) begin
			pending_cells[pending_cells.size() - 1].last = 1;
			pending_cells[pending_cells.size() - 1].trunc = trunc;
		end
	endfunction

	function void check_cell(logic [47:0] data, logic last, logic trunc);
		cell_t e;
		if (pending_cells.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected cell x=%0d y=%0d last=%b trunc=%b",
					$signed(data[23:0]), $signed(data[47:24]), last, trunc);
			return;
		end
		e = pending_cells.pop_front();
		if (data[23:0] !== e.cx || data[47:24] !== e.cy || last !== e.last ||
			trunc !== e.trunc) begin
			mismatches++;
			if (mismatches <= 10)
				$display("cell mismatch: expected x=%0d y=%0d last=%b trunc=%b, got x=%0d y=%0d last=%b trunc=%b",
					$signed(e.cx), $signed(e.cy), e.last, e.trunc,
					$signed(data[23:0]), $signed(data[47:24]), last, trunc);
		end
	endfunction
endclass

module tb_grid_ray_cell_walker;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] ADDR_GRID_SIZE  = 3'd0;
	localparam logic [2:0] ADDR_MARGIN     = 3'd4;
	localparam int         DRAIN_CYCLES    = 400;
	localparam longint     CYCLE_LIMIT     = 600000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [95:0] s_tdata = '0;   // origin_x, origin_y, target_x, target_y
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [47:0] m_tdata;        // cell_x, cell_y
	logic        m_tlast;        // last_cell
	logic        m_tuser;        // truncated
	logic        psel = 0;
	logic        penable = 0;
	logic        pwrite = 0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	cell_walk_scoreboard cells = new();
	bit     steady = 0;
	longint cycles = 0;

	grid_ray_cell_walker dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			cells.check_cell(m_tdata, m_tlast, m_tuser);
		m_tready <= steady || ($urandom_range(99, 0) >= 31);
	end

	task automatic send_ray(logic [23:0] ox, logic [23:0] oy, logic [23:0] tx,
		logic [23:0] ty);
		if (!steady && $urandom_range(99, 0) < 31) begin
			s_tvalid <= 0;
			do @(posedge clk); while ($urandom_range(99, 0) < 31);
		end
		s_tvalid <= 1;
		s_tdata <= {ty, tx, oy, ox};
		do @(posedge clk); while (!s_tready);
		cells.note_ray(ox, oy, tx, ty);
	endtask

	// Waits until every expected cell is out and any dropped ray has finished.
	task automatic drain();
		s_tvalid <= 0;
		while (cells.pending_cells.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [15:0] value);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (addr == ADDR_GRID_SIZE) cells.cell_edge = value;
		else cells.margin = value;
	endtask

	task automatic set_grid(logic [15:0] vs, logic [15:0] m);
		drain();
		apb_write(ADDR_GRID_SIZE, vs);
		apb_write(ADDR_MARGIN, m);
	endtask

	function automatic logic [23:0] clamp24(longint v);
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		return v[23:0];
	endfunction

	task automatic random_ray();
		logic [23:0] ox, oy;
		longint      vs, dx, dy, m;
		int          pick;
		vs = cells.cell_edge == 0 ? 1 : cells.cell_edge;
		m = cells.margin;
		ox = 24'($urandom());
		oy = 24'($urandom());
		pick = $urandom_range(99, 0);
		if (pick < 15) begin
			send_ray(ox, oy, 24'($urandom()), 24'($urandom()));
			return;
		end else if (pick < 25) begin
			// Ray no longer than the margin.
			dx = $urandom_range(m, 0);
			dy = 0;
		end else if (pick < 35) begin
			// Origin on a cell corner, target less than one cell away per axis.
			dx = $urandom_range(vs - 1, 0);
			dy = $urandom_range(vs - 1, 0);
			ox = clamp24(longint'($signed(ox)) / vs * vs);
			oy = clamp24(longint'($signed(oy)) / vs * vs);
		end else if (pick < 45) begin
			dx = longint'($urandom_range(40, 0)) * vs;
			dy = dx;
			ox = clamp24(longint'($signed(ox)) / vs * vs);
			oy = ox;
		end else begin
			dx = longint'($urandom_range(40 * vs + m, 0));
			dy = longint'($urandom_range(40 * vs + m, 0));
		end
		if ($urandom_range(1, 0)) dx = -dx;
		if ($urandom_range(1, 0)) dy = -dy;
		send_ray(ox, oy, clamp24(longint'($signed(ox)) + dx),
			clamp24(longint'($signed(oy)) + dy));
	endtask

	initial begin
		logic [15:0] vs_list[6];
		logic [15:0] m_list[6];
		vs_list = '{16'd256, 16'd0, 16'd65535, 16'd1, 16'd100, 16'd4096};
		m_list  = '{16'd0, 16'd0, 16'd65535, 16'd3, 16'd300, 16'd20000};
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed rays at the reset grid.
		send_ray(24'd0, 24'd0, 24'd0, 24'd0);
		send_ray(24'd10, 24'd10, 24'd300, 24'd10);
		send_ray(24'd0, 24'd0, 24'd1024, 24'd1024);
		send_ray(24'd0, 24'd0, -24'sd700, 24'd200);
		send_ray(24'd5, -24'sd5, 24'd5, -24'sd2000);
		send_ray(24'd255, 24'd255, 24'd256, 24'd256);
		send_ray(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff);
		send_ray(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000);
		send_ray(24'h7fffff, 24'h800000, 24'h7ff000, 24'h800400);
		send_ray(-24'sd256, 24'd0, 24'd0, 24'd100);
		set_grid(16'd0, 16'd0);
		send_ray(24'd0, 24'd0, 24'd5, 24'd3);
		send_ray(24'd7, 24'd7, 24'd2, 24'd9);
		send_ray(24'd0, 24'd0, 24'd200, 24'd0);
		set_grid(16'd256, 16'd500);
		send_ray(24'd0, 24'd0, 24'd500, 24'd0);
		send_ray(24'd0, 24'd0, 24'd501, 24'd0);
		send_ray(24'd0, 24'd0, 24'd300, 24'd400);
		send_ray(24'd100, 24'd100, 24'd3000, -24'sd2000);
		set_grid(16'd65535, 16'd65535);
		send_ray(24'h800000, 24'd0, 24'h7fffff, 24'd0);
		send_ray(24'd0, 24'h7fffff, 24'd0, 24'h800000);

		for (int ph = 0; ph < 6; ph++) begin
			set_grid(vs_list[ph], m_list[ph]);
			for (int i = 0; i < 14; i++) begin
				steady = (ph == 2);
				random_ray();
			end
		end
		steady = 0;
		drain();
		if (cells.mismatches == 0 && cells.pending_cells.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

`default_nettype wire
